FILE: sv/dlpe_pkg.sv
// dlpe_pkg: shared types and codes for the dhcp lease pool engine
// no dependencies
package dlpe_pkg;

  typedef enum logic [2:0] {
    ACT_OFFER   = 3'd0,
    ACT_CANCEL  = 3'd1,
    ACT_ALLOC   = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_RENEW   = 3'd4,
    ACT_RESERVE = 3'd5,
    ACT_TICK    = 3'd6,
    ACT_NONE    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NONE     = 3'd1,
    STS_RSV_BUSY = 3'd2,
    STS_OUT_POOL = 3'd3,
    STS_LEASED   = 3'd4,
    STS_RSV_OTH  = 3'd5,
    STS_FULL     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ES_FREE    = 2'd0,
    ES_LEASED  = 2'd1,
    ES_OFFERED = 2'd2
  } entry_state_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_SWEEP = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RSV,
    S_RSV_FILL,
    S_ONE_RD,
    S_ONE_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_REOFFER,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] client_mac;
    logic [31:0] request_ip;
    logic [31:0] lease_seconds;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_ip;
    logic [7:0]  entry_index;
  } rsp_t;

endpackage

FILE: sv/dlpe_if.sv
// dlpe_if: valid/ready channel carrying one word of type T
// no dependencies; the payload type T is a parameter
interface dlpe_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/dhcp_lease_pool_engine.sv
// dhcp_lease_pool_engine: dhcp pool binding table in a single-port memory, plus reservations
// depends on dlpe_pkg and dlpe_if
//
// channel | dir | payload
// in_*    | in  | action, client_mac, request_ip, lease_seconds
// out_*   | out | status, result_ip, entry_index
// cfg_*   | in  | write enable, index, 32-bit data
//
// offer and reserve search the reservations; a reserved offer, reserve, allocate,
// release and renew then read one entry; any other offer, cancel and sweeping tick scan
// the pool; after reset a clearing pass zeroes all pool entries before in_ready rises
// one word in flight; out register holds the last result while out_ready is low,
// the next word is accepted meanwhile and waits in done until the register frees
module dhcp_lease_pool_engine
  import dlpe_pkg::*;
#(
  parameter int POOL_DEPTH = 256,
  parameter int RESV_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dlpe_if.sink        in_ch,
  dlpe_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int RW = (RESV_DEPTH > 1) ? $clog2(RESV_DEPTH) : 1;

  logic [31:0] start_r, end_r;
  logic [8:0]  count_r;
  logic [7:0]  period_r;
  logic [31:0] sec_r;
  logic [7:0]  swc_r;

  // binding memory: {state, mac, start, len}
  logic [113:0] pmem [POOL_DEPTH];
  logic [113:0] prd_r;
  logic         pwe;
  logic [PW-1:0] paddr;
  logic [113:0] pwd;
  // reservation memory: {mac, addr}
  logic [79:0]  rmem [RESV_DEPTH];
  logic [RESV_DEPTH-1:0] rvalid_r;

  fsm_t st_r, st_nxt;
  req_t req_r;
  rsp_t rsp_r;
  rsp_t odata_r;
  logic out_v_r;
  logic ld_out;
  logic [PW:0] i_r;
  logic [PW:0] clr_r;
  logic [RW:0] k_r;
  logic seen_r, hit_r;
  logic [PW:0] first_r;
  logic [PW:0] n;
  logic [31:0] rel;
  logic        rel_ok;
  logic        sweep_r;
  logic        rhit_r;
  logic [79:0] rrow;
  logic [RW:0] rslot_r;
  logic        rmac_r;  // reserve hit found by mac (else by addr)
  logic        rfree_seen_r;
  logic [RW:0] rfree_r;

  assign n = (count_r >= 9'(POOL_DEPTH)) ? (PW+1)'(POOL_DEPTH) : (PW+1)'(count_r);
  assign rel = req_r.request_ip - start_r;
  assign rel_ok = ({1'b0, rel} < {{(33-(PW+1)){1'b0}}, n});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0; end_r <= '0; count_r <= 9'd256; period_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START: start_r <= cfg_data;
        CFG_END:   end_r <= cfg_data;
        CFG_COUNT: count_r <= cfg_data[8:0];
        CFG_SWEEP: period_r <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) pmem[paddr] <= pwd;
    prd_r <= pmem[paddr];
  end

  logic [1:0] es;
  logic [47:0] emac;
  logic [31:0] estart, elen;
  assign es = prd_r[113:112];
  assign emac = prd_r[111:64];
  assign estart = prd_r[63:32];
  assign elen = prd_r[31:0];
  assign rrow = rmem[k_r[RW-1:0]];

  assign ld_out = (st_r == S_DONE) && (!out_v_r || out_ch.ready);
  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.data = odata_r;

  function automatic rsp_t mk(status_t s, logic [31:0] base, logic [PW:0] idx, logic has);
    rsp_t r;
    r.status = s;
    r.result_ip = has ? base + 32'(idx) : '0;
    r.entry_index = has ? idx[7:0] : '0;
    return r;
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_CLEAR:  if (clr_r == (PW+1)'(POOL_DEPTH - 1)) st_nxt = S_IDLE;
      S_IDLE:   if (in_ch.valid && in_ch.ready) begin
        unique case (action_t'(in_ch.data.action))
          ACT_OFFER, ACT_RESERVE: st_nxt = S_RSV;
          ACT_CANCEL: st_nxt = S_SCAN_RD;
          ACT_ALLOC, ACT_RELEASE, ACT_RENEW: st_nxt = S_ONE_RD;
          ACT_TICK: st_nxt = S_SCAN_RD;
          ACT_NONE: st_nxt = S_DONE;
        endcase
      end
      default: st_nxt = st_r;
    endcase
  end

  // datapath and output sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; out_v_r <= 1'b0; rvalid_r <= '0;
      sec_r <= '0; swc_r <= '0; i_r <= '0; k_r <= '0;
    end else begin
      if (ld_out) out_v_r <= 1'b1;
      else if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          st_r <= st_nxt;
        end
        S_IDLE: begin
          st_r <= st_nxt;
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.data;
            i_r <= '0; k_r <= '0; seen_r <= 1'b0; hit_r <= 1'b0; first_r <= '0;
            rhit_r <= 1'b0; rfree_seen_r <= 1'b0; rmac_r <= 1'b0; sweep_r <= 1'b0;
            rsp_r <= mk(STS_NONE, '0, '0, 1'b0);
            if (action_t'(in_ch.data.action) == ACT_TICK) begin
              sec_r <= sec_r + 1'b1;
              if (swc_r + 8'd1 >= period_r) begin
                swc_r <= '0; sweep_r <= 1'b1;
              end else swc_r <= swc_r + 8'd1;
            end
          end
        end
        S_RSV: begin
          // reservation search: offer by mac, reserve by addr and mac and free slot
          if (k_r == (RW+1)'(RESV_DEPTH)) st_r <= S_RSV_FILL;
          else begin
            if (rvalid_r[k_r[RW-1:0]]) begin
              if (action_t'(req_r.action) == ACT_OFFER) begin
                if (!rhit_r && rrow[79:32] == req_r.client_mac) begin
                  rhit_r <= 1'b1; rslot_r <= k_r;
                end
              end else begin
                if (rrow[31:0] == req_r.request_ip && !(rhit_r && !rmac_r)) begin
                  rhit_r <= 1'b1; rmac_r <= 1'b0; rslot_r <= k_r;
                end else if (!rhit_r && rrow[79:32] == req_r.client_mac) begin
                  rhit_r <= 1'b1; rmac_r <= 1'b1; rslot_r <= k_r;
                end
              end
            end else if (!rfree_seen_r) begin
              rfree_seen_r <= 1'b1; rfree_r <= k_r;
            end
            k_r <= k_r + 1'b1;
          end
        end
        S_RSV_FILL: begin
          if (action_t'(req_r.action) == ACT_OFFER) begin
            if (rhit_r) begin
              k_r <= rslot_r;
              req_r.request_ip <= rmem[rslot_r[RW-1:0]][31:0];
              st_r <= S_ONE_RD;
            end else st_r <= S_SCAN_RD;
          end else begin
            if (req_r.request_ip < start_r || req_r.request_ip > end_r || !rel_ok) begin
              rsp_r <= mk(STS_OUT_POOL, '0, '0, 1'b0); st_r <= S_DONE;
            end else st_r <= S_ONE_RD;
          end
        end
        S_ONE_RD: begin
          if (!rel_ok) begin
            rsp_r <= mk((action_t'(req_r.action) == ACT_OFFER) ? STS_OUT_POOL : STS_NONE,
                        '0, '0, 1'b0);
            st_r <= S_DONE;
          end else st_r <= S_ONE_CHK;
        end
        S_ONE_CHK: begin
          st_r <= S_DONE;
          unique case (action_t'(req_r.action))
            ACT_OFFER:
              if (es != ES_FREE) rsp_r <= mk(STS_RSV_BUSY, start_r, (PW+1)'(rel), 1'b1);
              else rsp_r <= mk(STS_OK, start_r, (PW+1)'(rel), 1'b1);
            ACT_ALLOC:
              if (es == ES_OFFERED && emac == req_r.client_mac)
                rsp_r <= mk(STS_OK, start_r, (PW+1)'(rel), 1'b1);
            ACT_RELEASE, ACT_RENEW:
              if (es == ES_LEASED && emac == req_r.client_mac)
                rsp_r <= mk(STS_OK, start_r, (PW+1)'(rel), 1'b1);
            ACT_RESERVE: begin
              if (es != ES_FREE) rsp_r <= mk(STS_LEASED, start_r, (PW+1)'(rel), 1'b1);
              else if (rhit_r && !rmac_r) begin
                rsp_r <= mk((rmem[rslot_r[RW-1:0]][79:32] == req_r.client_mac) ? STS_OK
                            : STS_RSV_OTH, start_r, (PW+1)'(rel), 1'b1);
              end else if (rhit_r) begin
                rmem[rslot_r[RW-1:0]][31:0] <= req_r.request_ip;
                rsp_r <= mk(STS_OK, start_r, (PW+1)'(rel), 1'b1);
              end else if (rfree_seen_r) begin
                rmem[rfree_r[RW-1:0]] <= {req_r.client_mac, req_r.request_ip};
                rvalid_r[rfree_r[RW-1:0]] <= 1'b1;
                rsp_r <= mk(STS_OK, start_r, (PW+1)'(rel), 1'b1);
              end else rsp_r <= mk(STS_FULL, start_r, (PW+1)'(rel), 1'b1);
            end
            default: ;
          endcase
        end
        S_SCAN_RD: begin
          if (action_t'(req_r.action) == ACT_TICK && !sweep_r) begin
            rsp_r <= mk(STS_OK, '0, '0, 1'b0); st_r <= S_DONE;
          end else if (i_r >= n) begin
            unique case (action_t'(req_r.action))
              ACT_OFFER: if (seen_r) begin
                i_r <= first_r; st_r <= S_REOFFER;
              end else st_r <= S_DONE;
              ACT_CANCEL: begin
                if (hit_r) rsp_r <= mk(STS_OK, start_r, first_r, 1'b1);
                st_r <= S_DONE;
              end
              default: begin rsp_r <= mk(STS_OK, '0, '0, 1'b0); st_r <= S_DONE; end
            endcase
          end else st_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          st_r <= S_SCAN_RD;
          i_r <= i_r + 1'b1;
          unique case (action_t'(req_r.action))
            ACT_OFFER:
              if (es == ES_OFFERED && !seen_r) begin
                seen_r <= 1'b1; first_r <= i_r;
              end else if (es == ES_FREE) begin
                rsp_r <= mk(STS_OK, start_r, i_r, 1'b1); st_r <= S_DONE;
              end
            ACT_CANCEL:
              if (es == ES_OFFERED && emac == req_r.client_mac && !hit_r) begin
                hit_r <= 1'b1; first_r <= i_r;
              end
            default: ;
          endcase
        end
        S_REOFFER: begin
          rsp_r <= mk(STS_OK, start_r, first_r, 1'b1); st_r <= S_DONE;
        end
        S_DONE: begin
          if (ld_out) begin
            odata_r <= rsp_r; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // memory port control
  always_comb begin
    pwe = 1'b0; paddr = i_r[PW-1:0]; pwd = prd_r;
    unique case (st_r)
      S_CLEAR: begin pwe = 1'b1; paddr = clr_r[PW-1:0]; pwd = '0; end
      S_ONE_RD: paddr = rel[PW-1:0];
      S_ONE_CHK: begin
        paddr = rel[PW-1:0];
        unique case (action_t'(req_r.action))
          ACT_OFFER: if (es == ES_FREE) begin
            pwe = 1'b1; pwd = {ES_OFFERED, req_r.client_mac, estart, elen};
          end
          ACT_ALLOC: if (es == ES_OFFERED && emac == req_r.client_mac) begin
            pwe = 1'b1; pwd = {ES_LEASED, emac, sec_r, req_r.lease_seconds};
          end
          ACT_RELEASE: if (es == ES_LEASED && emac == req_r.client_mac) begin
            pwe = 1'b1; pwd = {ES_FREE, emac, estart, elen};
          end
          ACT_RENEW: if (es == ES_LEASED && emac == req_r.client_mac) begin
            pwe = 1'b1; pwd = {ES_LEASED, emac, estart, req_r.lease_seconds};
          end
          default: ;
        endcase
      end
      S_SCAN_CHK: begin
        paddr = i_r[PW-1:0];
        unique case (action_t'(req_r.action))
          ACT_OFFER: if (es == ES_FREE && !(es == ES_OFFERED && !seen_r)) begin
            pwe = 1'b1; pwd = {ES_OFFERED, req_r.client_mac, estart, elen};
          end
          ACT_CANCEL: if (es == ES_OFFERED && emac == req_r.client_mac) begin
            pwe = 1'b1; pwd = {ES_FREE, 48'd0, estart, elen};
          end
          ACT_TICK: if (es == ES_LEASED && (sec_r - estart) > elen) begin
            pwe = 1'b1; pwd = {ES_FREE, emac, estart, elen};
          end
          default: ;
        endcase
      end
      S_REOFFER: begin
        paddr = first_r[PW-1:0]; pwe = 1'b1;
        pwd = {ES_OFFERED, req_r.client_mac, 64'd0};
      end
      default: ;
    endcase
  end

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("accept while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> ($stable(odata_r) && out_v_r)) else $error("result lost");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && !out_v_r) |=> out_v_r) else $error("no result");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> !in_ch.ready) else $error("accept during clear");

endmodule
